[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/drcs_pkg.sv]
// ----------------------------------------------------------------------------
// drcs_pkg
// Types, codes and constants of the digital rain column stepper.
// ----------------------------------------------------------------------------
package drcs_pkg;

    typedef struct packed {
        logic       func;
        logic [6:0] column;
    } t_in;

    typedef struct packed {
        logic [6:0] cell_col;
        logic [7:0] cell_row;
        logic [1:0] cell_kind;
        logic [7:0] glyph;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic       colored;
        logic       last_cell;
    } t_out;

    localparam logic FUNC_INIT = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_TAIL  = 2'd1;
    localparam logic [1:0] KIND_HEAD  = 2'd2;

    localparam logic [2:0] CFG_LEN_MIN   = 3'd0;
    localparam logic [2:0] CFG_LEN_MAX   = 3'd1;
    localparam logic [2:0] CFG_SPD_MIN   = 3'd2;
    localparam logic [2:0] CFG_SPD_MAX   = 3'd3;
    localparam logic [2:0] CFG_ROWS      = 3'd4;
    localparam logic [2:0] CFG_BINARY    = 3'd5;
    localparam logic [2:0] CFG_COLORS    = 3'd6;
    localparam logic [2:0] CFG_BASE_SEED = 3'd7;

    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [7:0]  SPACE    = 8'h20;
    localparam logic [5:0]  LEN_CAP  = 6'd48;
    localparam logic [12:0] GREEN_TOP  = 13'd245;
    localparam logic [12:0] GREEN_SPAN = 13'd150;
    localparam logic [12:0] GREEN_KNEE = 13'd175;
    localparam logic [7:0]  GREEN_MIN  = 8'd70;
    localparam logic [12:0] BLUE_TOP   = 13'd200;
    localparam logic [12:0] BLUE_SPAN  = 13'd140;
    localparam logic [12:0] BLUE_KNEE  = 13'd170;
    localparam logic [7:0]  BLUE_MIN   = 8'd30;

    function automatic logic [63:0] mix(input logic [63:0] s);
        logic [63:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    function automatic logic [7:0] glyph_full(input logic [3:0] k);
        logic [7:0] g;
        case (k)
            4'd0:    g = 8'h30;
            4'd1:    g = 8'h31;
            4'd2:    g = 8'h23;
            4'd3:    g = 8'h2F;
            4'd4:    g = 8'h5C;
            4'd5:    g = 8'h7C;
            4'd6:    g = 8'h5B;
            4'd7:    g = 8'h5D;
            4'd8:    g = 8'h7B;
            4'd9:    g = 8'h7D;
            4'd10:   g = 8'h3C;
            4'd11:   g = 8'h3E;
            4'd12:   g = 8'h2B;
            4'd13:   g = 8'h3D;
            4'd14:   g = 8'h2D;
            default: g = 8'h2A;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] glyph_bin(input logic k);
        return k ? 8'h31 : 8'h30;
    endfunction

endpackage

[rtl/digital_rain_column_stepper_top.sv]
// ----------------------------------------------------------------------------
// digital_rain_column_stepper_top: one shared divider and one serial multiplier.
// Init: four range draws, no cells.
// Step: clear cells for the rows passed over, then tail cells and a head cell;
//   a respawn adds an init-like sequence.
// Reset clears the sequencer and handshakes and restores the configuration defaults; column stores keep data.
// ----------------------------------------------------------------------------
module digital_rain_column_stepper_top #(
    parameter int COLUMNS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  drcs_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output drcs_pkg::t_out     o_out_data
);

    localparam int IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [3:0] MUL_BITS = 4'd12;
    localparam logic [6:0] DIV_WIDE = 7'd64;
    localparam logic [6:0] DIV_GRAD = 7'd13;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LOAD    = 5'd1;
    localparam logic [4:0] S_CLR     = 5'd2;
    localparam logic [4:0] S_GLY     = 5'd3;
    localparam logic [4:0] S_DIV     = 5'd4;
    localparam logic [4:0] S_GRAD1   = 5'd5;
    localparam logic [4:0] S_GRAD2   = 5'd6;
    localparam logic [4:0] S_GLYPH   = 5'd7;
    localparam logic [4:0] S_GEMIT   = 5'd8;
    localparam logic [4:0] S_WB      = 5'd9;
    localparam logic [4:0] S_MUL     = 5'd10;
    localparam logic [4:0] S_MIX     = 5'd11;
    localparam logic [4:0] S_DRAW    = 5'd12;
    localparam logic [4:0] S_DRAWFIN = 5'd13;
    localparam logic [4:0] S_DRAWRES = 5'd14;
    localparam logic [4:0] S_WR      = 5'd15;
    localparam logic [4:0] S_FIN     = 5'd16;

    localparam logic [2:0] D_LEN   = 3'd0;
    localparam logic [2:0] D_SPD   = 3'd1;
    localparam logic [2:0] D_PHASE = 3'd2;
    localparam logic [2:0] D_MULT  = 3'd3;
    localparam logic [2:0] D_POS   = 3'd4;

    // Configuration.
    logic [5:0]  r_len_min, r_len_max;
    logic [3:0]  r_spd_min, r_spd_max;
    logic [7:0]  r_rows;
    logic        r_binary, r_colors;
    logic [63:0] r_base_seed;

    // Column stores.
    logic [5:0]  r_mem_len  [COLUMNS];
    logic [11:0] r_mem_pos  [COLUMNS];
    logic [3:0]  r_mem_spd  [COLUMNS];
    logic [63:0] r_mem_seed [COLUMNS];
    logic [5:0]  r_rd_len;
    logic [11:0] r_rd_pos;
    logic [3:0]  r_rd_spd;
    logic [63:0] r_rd_seed;

    // Sequencer and working state.
    logic [4:0]  r_state, r_dret;
    logic [6:0]  r_col;
    logic [IW-1:0] r_idx;
    logic        r_isstep, r_resp;
    logic [5:0]  r_len, r_i;
    logic [11:0] r_pos, r_next;
    logic [3:0]  r_spd;
    logic [63:0] r_seed;
    logic [2:0]  r_dcode, r_mfac;
    logic [9:0]  r_dres;
    logic [1:0]  r_kind;
    logic [7:0]  r_glyph, r_green, r_blue;

    // Shared divider and serial multiplier.
    logic [63:0] r_dvd;
    logic [9:0]  r_rem, r_dsr;
    logic [6:0]  r_dcnt;
    logic [63:0] r_macc, r_mcand;
    logic [11:0] r_mplr;
    logic [3:0]  r_mcnt;

    // Output side.
    logic           r_pend_v, r_ov;
    drcs_pkg::t_out r_pend, r_out;

    logic           w_in_acc, w_in_range;
    logic [IW-1:0]  w_idx;
    logic [11:0]    w_base;
    logic [12:0]    w_row;
    logic           w_vis, w_ofree, w_can, w_emit, w_flush, w_push;
    drcs_pkg::t_out w_cell, w_pushcell;
    logic [9:0]     w_lo, w_hi, w_rm;
    logic [10:0]    w_rm_full, w_rsh, w_rsub;
    logic           w_ge;
    logic [12:0]    w_q, w_lim;
    logic           w_respawn;
    logic [63:0]    w_mix;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_in_range  = {2'b0, i_in_data.column} < 9'(COLUMNS);
    assign w_idx       = IW'({1'b0, i_in_data.column});
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign w_mix       = drcs_pkg::mix(r_seed);

    assign w_rsh  = {r_rem, r_dvd[63]};
    assign w_rsub = w_rsh - {1'b0, r_dsr};
    assign w_ge   = (w_rsh >= {1'b0, r_dsr});
    assign w_q    = r_dvd[12:0];

    assign w_lim     = {5'b0, r_rows} + {7'b0, r_len};
    assign w_respawn = !r_next[11] && ({1'b0, r_next} > w_lim);

    assign w_rm_full = {3'b0, r_rows} * {8'b0, r_mfac};
    assign w_rm      = w_rm_full[9:0];

    always_comb begin
        case (r_dcode)
            D_LEN: begin
                w_lo = {4'b0, r_len_min};
                w_hi = {4'b0, r_len_max};
            end
            D_SPD: begin
                w_lo = {6'b0, r_spd_min};
                w_hi = {6'b0, r_spd_max};
            end
            D_PHASE: begin
                w_lo = 10'd0;
                w_hi = 10'd3;
            end
            D_MULT: begin
                w_lo = 10'd1;
                w_hi = 10'd3;
            end
            default: begin
                w_lo = 10'd0;
                w_hi = w_rm;
            end
        endcase
    end

    always_comb begin
        w_base  = (r_state == S_CLR) ? r_pos : r_next;
        w_row   = {w_base[11], w_base} + {7'b0, r_i};
        w_vis   = !w_row[12] && (w_row[11:0] < {4'b0, r_rows});
        w_ofree = !r_ov || i_out_ready;
        w_can   = !r_pend_v || w_ofree;
        w_emit  = 1'b0;
        w_cell  = '0;
        w_cell.cell_col = r_col;
        w_cell.cell_row = w_row[7:0];
        case (r_state)
            S_CLR: begin
                w_cell.cell_kind = drcs_pkg::KIND_CLEAR;
                w_cell.glyph     = drcs_pkg::SPACE;
                w_emit = (r_i < {2'b0, r_spd}) && w_vis && w_can;
            end
            S_GEMIT: begin
                w_cell.cell_kind   = r_kind;
                w_cell.glyph       = r_glyph;
                w_cell.green_level = r_green;
                w_cell.blue_level  = r_blue;
                w_cell.colored     = r_colors;
                w_emit = w_can;
            end
            default: w_emit = 1'b0;
        endcase
        w_flush    = (r_state == S_FIN) && r_pend_v && w_ofree;
        w_push     = (w_emit && r_pend_v) || w_flush;
        w_pushcell = r_pend;
        if (w_flush) begin
            w_pushcell.last_cell = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_min   <= 6'd3;
            r_len_max   <= 6'd20;
            r_spd_min   <= 4'd1;
            r_spd_max   <= 4'd3;
            r_rows      <= 8'd24;
            r_binary    <= 1'b0;
            r_colors    <= 1'b1;
            r_base_seed <= 64'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                drcs_pkg::CFG_LEN_MIN: r_len_min   <= i_cfg_data[5:0];
                drcs_pkg::CFG_LEN_MAX: r_len_max   <= i_cfg_data[5:0];
                drcs_pkg::CFG_SPD_MIN: r_spd_min   <= i_cfg_data[3:0];
                drcs_pkg::CFG_SPD_MAX: r_spd_max   <= i_cfg_data[3:0];
                drcs_pkg::CFG_ROWS:    r_rows      <= i_cfg_data[7:0];
                drcs_pkg::CFG_BINARY:  r_binary    <= i_cfg_data[0];
                drcs_pkg::CFG_COLORS:  r_colors    <= i_cfg_data[0];
                default:               r_base_seed <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd_len  <= r_mem_len[w_idx];
            r_rd_pos  <= r_mem_pos[w_idx];
            r_rd_spd  <= r_mem_spd[w_idx];
            r_rd_seed <= r_mem_seed[w_idx];
        end
        if (r_state == S_WR) begin
            r_mem_len[r_idx]  <= r_len;
            r_mem_pos[r_idx]  <= r_pos;
            r_mem_spd[r_idx]  <= r_spd;
            r_mem_seed[r_idx] <= r_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_pushcell;
        end
        if (w_emit) begin
            r_pend <= w_cell;
        end
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (w_emit) begin
                r_pend_v <= 1'b1;
            end else if (w_flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_col <= i_in_data.column;
                        r_idx <= w_idx;
                        if (w_in_range) begin
                            if (i_in_data.func == drcs_pkg::FUNC_STEP) begin
                                r_isstep <= 1'b1;
                                r_state  <= S_LOAD;
                            end else begin
                                r_isstep <= 1'b0;
                                r_resp   <= 1'b0;
                                r_seed   <= r_base_seed;
                                r_macc   <= '0;
                                r_mcand  <= drcs_pkg::GOLDEN;
                                r_mplr   <= {5'b0, i_in_data.column};
                                r_mcnt   <= MUL_BITS;
                                r_state  <= S_MUL;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_len   <= r_rd_len;
                    r_pos   <= r_rd_pos;
                    r_spd   <= r_rd_spd;
                    r_seed  <= r_rd_seed;
                    r_next  <= r_rd_pos + {8'b0, r_rd_spd};
                    r_i     <= '0;
                    r_state <= S_CLR;
                end
                S_CLR: begin
                    if (r_i >= {2'b0, r_spd}) begin
                        r_i     <= '0;
                        r_state <= S_GLY;
                    end else if (!w_vis || w_emit) begin
                        r_i <= r_i + 6'd1;
                    end
                end
                S_GLY: begin
                    if (r_i >= r_len) begin
                        r_state <= S_WB;
                    end else if (!w_vis) begin
                        r_i <= r_i + 6'd1;
                    end else if (r_i == r_len - 6'd1) begin
                        r_kind  <= drcs_pkg::KIND_HEAD;
                        r_green <= '0;
                        r_blue  <= '0;
                        r_state <= S_GLYPH;
                    end else begin
                        r_kind  <= drcs_pkg::KIND_TAIL;
                        r_dvd   <= {13'({7'b0, r_i} * drcs_pkg::GREEN_SPAN), 51'b0};
                        r_rem   <= '0;
                        r_dsr   <= {4'b0, r_len};
                        r_dcnt  <= DIV_GRAD;
                        r_dret  <= S_GRAD1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    r_rem  <= w_ge ? w_rsub[9:0] : w_rsh[9:0];
                    r_dvd  <= {r_dvd[62:0], w_ge};
                    r_dcnt <= r_dcnt - 7'd1;
                    if (r_dcnt == 7'd1) begin
                        r_state <= r_dret;
                    end
                end
                S_GRAD1: begin
                    r_green <= (w_q > drcs_pkg::GREEN_KNEE) ? drcs_pkg::GREEN_MIN
                                                           : 8'(drcs_pkg::GREEN_TOP - w_q);
                    r_dvd   <= {13'({7'b0, r_i} * drcs_pkg::BLUE_SPAN), 51'b0};
                    r_rem   <= '0;
                    r_dcnt  <= DIV_GRAD;
                    r_dret  <= S_GRAD2;
                    r_state <= S_DIV;
                end
                S_GRAD2: begin
                    r_blue  <= (w_q > drcs_pkg::BLUE_KNEE) ? drcs_pkg::BLUE_MIN
                                                          : 8'(drcs_pkg::BLUE_TOP - w_q);
                    r_state <= S_GLYPH;
                end
                S_GLYPH: begin
                    // Both glyph tables are powers of two, so the draw is a mask.
                    r_seed  <= w_mix;
                    r_glyph <= r_binary ? drcs_pkg::glyph_bin(w_mix[0])
                                        : drcs_pkg::glyph_full(w_mix[3:0]);
                    r_state <= S_GEMIT;
                end
                S_GEMIT: begin
                    if (w_emit) begin
                        r_i     <= r_i + 6'd1;
                        r_state <= S_GLY;
                    end
                end
                S_WB: begin
                    if (w_respawn) begin
                        r_resp  <= 1'b1;
                        r_macc  <= '0;
                        r_mcand <= drcs_pkg::GOLDEN;
                        r_mplr  <= r_next;
                        r_mcnt  <= MUL_BITS;
                        r_state <= S_MUL;
                    end else begin
                        r_pos   <= r_next;
                        r_state <= S_WR;
                    end
                end
                S_MUL: begin
                    if (r_mcnt != 4'd0) begin
                        if (r_mplr[0]) begin
                            r_macc <= r_macc + r_mcand;
                        end
                        r_mcand <= {r_mcand[62:0], 1'b0};
                        r_mplr  <= {1'b0, r_mplr[11:1]};
                        r_mcnt  <= r_mcnt - 4'd1;
                    end else begin
                        r_seed  <= r_seed ^ r_macc;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_seed  <= w_mix;
                    r_dcode <= D_LEN;
                    r_state <= S_DRAW;
                end
                S_DRAW: begin
                    if (w_lo >= w_hi) begin
                        r_dres  <= w_lo;
                        r_state <= S_DRAWRES;
                    end else begin
                        r_seed  <= w_mix;
                        r_dvd   <= w_mix;
                        r_rem   <= '0;
                        r_dsr   <= w_hi - w_lo + 10'd1;
                        r_dcnt  <= DIV_WIDE;
                        r_dret  <= S_DRAWFIN;
                        r_state <= S_DIV;
                    end
                end
                S_DRAWFIN: begin
                    r_dres  <= w_lo + r_rem;
                    r_state <= S_DRAWRES;
                end
                S_DRAWRES: begin
                    r_state <= S_DRAW;
                    case (r_dcode)
                        D_LEN: begin
                            r_len   <= (r_dres > {4'b0, drcs_pkg::LEN_CAP}) ? drcs_pkg::LEN_CAP
                                                                           : r_dres[5:0];
                            r_dcode <= r_resp ? D_MULT : D_SPD;
                        end
                        D_SPD: begin
                            r_spd <= r_dres[3:0];
                            if (r_resp) begin
                                r_state <= S_WR;
                            end else begin
                                r_dcode <= D_PHASE;
                            end
                        end
                        D_PHASE: begin
                            r_mfac  <= r_dres[2:0] + 3'd1;
                            r_dcode <= D_POS;
                        end
                        D_MULT: begin
                            r_mfac  <= r_dres[2:0];
                            r_dcode <= D_POS;
                        end
                        default: begin
                            r_pos <= 12'd0 - {2'b0, r_dres};
                            if (r_resp) begin
                                r_dcode <= D_SPD;
                            end else begin
                                r_state <= S_WR;
                            end
                        end
                    endcase
                end
                S_WR: begin
                    r_state <= r_isstep ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    // The held cell goes out last, marked as the final one.
                    if (!r_pend_v || w_flush) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/drcs_checker.sv]
// ----------------------------------------------------------------------------
// drcs_port_props
// Port-level checks of the digital rain column stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drcs_port_props (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input drcs_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input drcs_pkg::t_out o_out_data
);

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output dropped while stalled")
    `CHK_NEXT(a_step_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.func == drcs_pkg::FUNC_STEP), !o_in_ready, "step transfer did not occupy the block")
    `CHK_NOW(a_kind_code, i_clk, i_rst_n, o_out_valid, o_out_data.cell_kind != 2'd3, "unused cell kind")
    `CHK_NOW(a_clear_cell, i_clk, i_rst_n, o_out_valid && (o_out_data.cell_kind == drcs_pkg::KIND_CLEAR), (o_out_data.glyph == drcs_pkg::SPACE) && (o_out_data.green_level == 8'd0) && (o_out_data.blue_level == 8'd0) && !o_out_data.colored, "malformed clear cell")
    `CHK_NOW(a_head_cell, i_clk, i_rst_n, o_out_valid && (o_out_data.cell_kind == drcs_pkg::KIND_HEAD), (o_out_data.green_level == 8'd0) && (o_out_data.blue_level == 8'd0), "head cell carries gradient")

endmodule

bind digital_rain_column_stepper_top drcs_port_props u_drcs_port_props (.*);

[test/drcs_checker.sv]
// ----------------------------------------------------------------------------
// drcs_checker
// Watches the configuration port and both channels of the digital rain column
// stepper, predicts the cells that every accepted item must produce and
// compares each accepted cell with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module drcs_checker #(
    parameter int COLUMNS = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [63:0]    i_cfg_data,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  drcs_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  drcs_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_cells_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam string GLYPHS_FULL = "01#/\\|[]{}<>+=-*";
    localparam string GLYPHS_BIN  = "01";

    int unsigned  len_lo, len_hi, spd_lo, spd_hi, rows;
    bit           binary_mode, colour_mode;
    logic [63:0]  seed_base;

    int           trail_len [COLUMNS];
    int           head_row  [COLUMNS];
    int           fall_rate [COLUMNS];
    logic [63:0]  col_seed  [COLUMNS];

    drcs_pkg::t_out cells_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_cells_seen = 0;
    end

    function automatic logic [63:0] xorshift(inout logic [63:0] s);
        s = s ^ (s << 13);
        s = s ^ (s >> 7);
        s = s ^ (s << 17);
        return s;
    endfunction

    // A range with min at or above max yields min without consuming the seed.
    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                         inout logic [63:0] s);
        logic [63:0] r;
        if (lo >= hi) return lo;
        r = xorshift(s);
        return lo + int'(r % 64'(hi - lo + 1));
    endfunction

    function automatic int unsigned pick_len(inout logic [63:0] s);
        int unsigned v;
        v = pick(len_lo, len_hi, s);
        return (v > 48) ? 48 : v;
    endfunction

    task automatic predict(input drcs_pkg::t_in item);
        int             c, len, pos, rate, nxt, r, gg, bb;
        int unsigned    ph, p, m;
        logic [63:0]    s;
        drcs_pkg::t_out entry;
        drcs_pkg::t_out cells [$];
        c = int'(item.column);
        if (c >= COLUMNS) return;
        if (item.func == drcs_pkg::FUNC_INIT) begin
            s = seed_base ^ (64'(c) * drcs_pkg::GOLDEN);
            void'(xorshift(s));
            trail_len[c] = pick_len(s);
            fall_rate[c] = pick(spd_lo, spd_hi, s);
            ph           = pick(0, 3, s);
            p            = pick(0, rows * (ph + 1), s);
            head_row[c]  = -int'(p);
            col_seed[c]  = s;
            return;
        end
        len  = trail_len[c];
        pos  = head_row[c];
        rate = fall_rate[c];
        s    = col_seed[c];
        nxt  = pos + rate;
        for (int i = 0; i < rate; i++) begin
            r = pos + i;
            if (r >= 0 && r < int'(rows)) begin
                entry = '0;
                entry.cell_col  = 7'(c);
                entry.cell_row  = 8'(r);
                entry.cell_kind = drcs_pkg::KIND_CLEAR;
                entry.glyph     = drcs_pkg::SPACE;
                cells.push_back(entry);
            end
        end
        for (int i = 0; i < len; i++) begin
            r = nxt + i;
            if (r >= 0 && r < int'(rows)) begin
                entry = '0;
                entry.cell_col = 7'(c);
                entry.cell_row = 8'(r);
                if (i == len - 1) begin
                    entry.cell_kind = drcs_pkg::KIND_HEAD;
                end else begin
                    gg = 245 - (i * 150) / len;
                    bb = 200 - (i * 140) / len;
                    entry.green_level = 8'((gg < 70) ? 70 : gg);
                    entry.blue_level  = 8'((bb < 30) ? 30 : bb);
                    entry.cell_kind   = drcs_pkg::KIND_TAIL;
                end
                if (binary_mode) entry.glyph = GLYPHS_BIN[pick(0, 1, s) & 1];
                else entry.glyph = GLYPHS_FULL[pick(0, 15, s) & 15];
                entry.colored = colour_mode;
                cells.push_back(entry);
            end
        end
        head_row[c] = nxt;
        col_seed[c] = s;
        // The trail has left the screen: reseed from its position and respawn.
        if (nxt > int'(rows) + len) begin
            s = s ^ (64'(longint'(nxt)) * drcs_pkg::GOLDEN);
            void'(xorshift(s));
            trail_len[c] = pick_len(s);
            m            = pick(1, 3, s);
            p            = pick(0, rows * m, s);
            head_row[c]  = -int'(p);
            fall_rate[c] = pick(spd_lo, spd_hi, s);
            col_seed[c]  = s;
        end
        if (cells.size() > 0) begin
            entry = cells[cells.size() - 1];
            entry.last_cell = 1'b1;
            cells[cells.size() - 1] = entry;
        end
        foreach (cells[k]) cells_due.push_back(cells[k]);
    endtask

    task automatic compare(input drcs_pkg::t_out got);
        drcs_pkg::t_out want;
        o_cells_seen++;
        if (cells_due.size() == 0) begin
            $error("cell transfer with nothing expected: col %0d row %0d",
                   got.cell_col, got.cell_row);
            o_fail_count++;
            return;
        end
        want = cells_due.pop_front();
        if (got.cell_col !== want.cell_col) begin
            $error("cell_col: expected %0d, got %0d", want.cell_col, got.cell_col);
            o_fail_count++;
        end
        if (got.cell_row !== want.cell_row) begin
            $error("cell_row: expected %0d, got %0d", want.cell_row, got.cell_row);
            o_fail_count++;
        end
        if (got.cell_kind !== want.cell_kind) begin
            $error("cell_kind: expected %0d, got %0d", want.cell_kind, got.cell_kind);
            o_fail_count++;
        end
        if (got.glyph !== want.glyph) begin
            $error("glyph: expected %0h, got %0h", want.glyph, got.glyph);
            o_fail_count++;
        end
        if (got.green_level !== want.green_level) begin
            $error("green_level: expected %0d, got %0d", want.green_level, got.green_level);
            o_fail_count++;
        end
        if (got.blue_level !== want.blue_level) begin
            $error("blue_level: expected %0d, got %0d", want.blue_level, got.blue_level);
            o_fail_count++;
        end
        if (got.colored !== want.colored) begin
            $error("colored: expected %0d, got %0d", want.colored, got.colored);
            o_fail_count++;
        end
        if (got.last_cell !== want.last_cell) begin
            $error("last_cell: expected %0d, got %0d", want.last_cell, got.last_cell);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_lo      = 3;
            len_hi      = 20;
            spd_lo      = 1;
            spd_hi      = 3;
            rows        = 24;
            binary_mode = 1'b0;
            colour_mode = 1'b1;
            seed_base   = 64'd1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    drcs_pkg::CFG_LEN_MIN:   len_lo      = i_cfg_data[5:0];
                    drcs_pkg::CFG_LEN_MAX:   len_hi      = i_cfg_data[5:0];
                    drcs_pkg::CFG_SPD_MIN:   spd_lo      = i_cfg_data[3:0];
                    drcs_pkg::CFG_SPD_MAX:   spd_hi      = i_cfg_data[3:0];
                    drcs_pkg::CFG_ROWS:      rows        = i_cfg_data[7:0];
                    drcs_pkg::CFG_BINARY:    binary_mode = i_cfg_data[0];
                    drcs_pkg::CFG_COLORS:    colour_mode = i_cfg_data[0];
                    drcs_pkg::CFG_BASE_SEED: seed_base   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict(i_in_data);
            if (i_out_valid && i_out_ready) compare(i_out_data);
            o_pending = cells_due.size();
        end
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives init and step items into the digital rain column stepper under a
// series of trail, speed, screen and glyph settings and several idling
// patterns, including a long receiver hold-off; a checker predicts every cell.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS      = 128;
    localparam int SETTLE     = 800;
    localparam int CYCLE_CAP  = 4000000;
    localparam int HOLD_LEN   = 3000;
    localparam int RAND_ITEMS = 27;

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           i_cfg_we   = 1'b0;
    logic [2:0]     i_cfg_idx  = '0;
    logic [63:0]    i_cfg_data = '0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    drcs_pkg::t_in  i_in_data  = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    drcs_pkg::t_out o_out_data;

    int fail_count, pending, cells_seen;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int items_sent = 0;
    int settings_run = 0;
    int live_cols [$];
    bit is_live [NCOLS];

    digital_rain_column_stepper_top #(.COLUMNS(NCOLS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    drcs_checker #(.COLUMNS(NCOLS)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_cells_seen (cells_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin : receiver
        int hold_cnt;
        bit hold_done;
        hold_cnt  = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_cnt  = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (int'($urandom_range(99)) >= stall_pct);
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item transfers.
    task automatic send_item(input logic func, input int col);
        drcs_pkg::t_in item;
        item.func   = func;
        item.column = 7'(col);
        if (int'($urandom_range(99)) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (int'($urandom_range(99)) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        forever begin
            @(negedge i_clk);
            if (o_in_ready) break;
        end
        @(posedge i_clk);
        items_sent++;
        if (func == drcs_pkg::FUNC_INIT && !is_live[col]) begin
            is_live[col] = 1'b1;
            live_cols.push_back(col);
        end
    endtask

    // The first edge lets the checker count the last transfer's cells.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !o_in_ready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input int lmin, input int lmax, input int smin,
                             input int smax, input int nrows, input bit bin,
                             input bit colour, input logic [63:0] seed);
        logic [63:0] vals [8];
        vals = '{64'(lmin), 64'(lmax), 64'(smin), 64'(smax), 64'(nrows),
                 64'(bin), 64'(colour), seed};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_run++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    initial begin : stimulus
        int col;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default-like settings, both edge columns, clears and tails.
        set_idling(0);
        apply_cfg(3, 20, 1, 3, 24, 1'b0, 1'b1, 64'd1);
        send_item(drcs_pkg::FUNC_INIT, 0);
        send_item(drcs_pkg::FUNC_INIT, 127);
        send_item(drcs_pkg::FUNC_INIT, 5);
        for (int k = 0; k < 4; k++) begin
            send_item(drcs_pkg::FUNC_STEP, 0);
            send_item(drcs_pkg::FUNC_STEP, 127);
            send_item(drcs_pkg::FUNC_STEP, 5);
        end
        wait_idle();

        // Directed: equal bounds, longest trail, fastest fall, one-row screen,
        // binary glyphs with colour off, so the trail respawns within a few steps.
        apply_cfg(48, 48, 15, 15, 1, 1'b1, 1'b0, '1);
        send_item(drcs_pkg::FUNC_INIT, 0);
        send_item(drcs_pkg::FUNC_INIT, 127);
        for (int k = 0; k < 4; k++) begin
            send_item(drcs_pkg::FUNC_STEP, 0);
            send_item(drcs_pkg::FUNC_STEP, 127);
        end
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0)
                apply_cfg(1, 48, 1, 15, 255, 1'b0, 1'b1, 64'd0);
            else if (ph == 7)
                apply_cfg(48, 1, 15, 1, 1, 1'b1, 1'b0, '1);
            else
                apply_cfg($urandom_range(1, 48), $urandom_range(1, 48),
                          $urandom_range(1, 15), $urandom_range(1, 15),
                          ($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(1, 40),
                          1'($urandom), 1'($urandom), {$urandom, $urandom});
            set_idling(ph % 4);
            if (ph == 4) hold_req = 1'b1;
            for (int k = 0; k < RAND_ITEMS; k++) begin
                // Mostly steps on live columns; some inits keep trails fresh.
                if (live_cols.size() == 0 || $urandom_range(99) < 20) begin
                    send_item(drcs_pkg::FUNC_INIT, $urandom_range(NCOLS - 1));
                end else begin
                    col = live_cols[$urandom_range(live_cols.size() - 1)];
                    send_item(drcs_pkg::FUNC_STEP, col);
                end
            end
            wait_idle();
        end

        $display("Run covered %0d item transfers and %0d cell transfers", items_sent,
                 cells_seen);
        $display("over %0d register settings and %0d live columns.", settings_run,
                 live_cols.size());
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
